// ===== hw/rtl/udh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package udh_pkg;

    localparam logic [31:0] SEED_FIRST_RST  = 32'h1357_9bdf;
    localparam logic [31:0] SEED_SECOND_RST = 32'h2468_ace1;

    localparam int KEY_W     = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SEED_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_SECOND = 1'b1;

    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_SEP  = 2'd1;
    localparam logic [1:0] OP_END  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TAKE,
        S_LOW,
        S_FLUSH
    } t_state;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_TAKE,
        CMD_LOW,
        CMD_RAW,
        CMD_SEP,
        CMD_END
    } t_cmd;

    typedef struct packed {
        logic [1:0] q_count;
        logic [1:0] pend_count;
        logic       take_long;
        logic       out_free;
    } t_status;

    // utf-8 sequence length from the lead byte, zero when it cannot lead
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if (b < 8'h80) begin
            len = 3'd1;
        end else if ((b & 8'he0) == 8'hc0) begin
            len = 3'd2;
        end else if ((b & 8'hf0) == 8'he0) begin
            len = 3'd3;
        end else if ((b & 8'hf8) == 8'hf0) begin
            len = 3'd4;
        end else begin
            len = 3'd0;
        end
        return len;
    endfunction

    // h*31 + u as shift and subtract
    function automatic logic [KEY_W-1:0] hash_step(input logic [KEY_W-1:0] h,
                                                   input logic [15:0] u);
        return (h << 5) - h + {{(KEY_W-16){1'b0}}, u};
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/udh_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface udh_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] text_byte;

    modport source (output valid, output op, output text_byte, input ready);
    modport sink   (input valid, input op, input text_byte, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/udh_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface udh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] key_first;
    logic [31:0] key_second;

    modport source (output valid, output key_first, output key_second, input ready);
    modport sink   (input valid, input key_first, input key_second, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/udh_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module udh_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [1:0]      i_in_op,
    input  logic            i_in_byte_nz,
    output logic            o_in_ready,
    input  udh_pkg::t_status i_status,
    output udh_pkg::t_cmd   o_cmd
);
    import udh_pkg::*;

    t_state r_state, n_state;
    logic   r_flush, n_flush;
    logic   r_end, n_end;
    logic   w_take_byte;
    logic   w_start_flush;

    assign w_take_byte   = (i_in_op == OP_BYTE) && i_in_byte_nz;
    assign w_start_flush = (i_in_op == OP_SEP) || (i_in_op == OP_END);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_flush <= 1'b0;
            r_end   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_flush <= n_flush;
            r_end   <= n_end;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_flush = r_flush;
        n_end   = r_end;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_flush = w_start_flush;
                    n_end   = (i_in_op == OP_END);
                    if (w_take_byte) begin
                        n_state = S_TAKE;
                    end else if (w_start_flush) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_TAKE: begin
                // queue pops this cycle
                if (i_status.take_long) begin
                    n_state = S_LOW;
                end else if (i_status.q_count > 2'd1) begin
                    n_state = S_TAKE;
                end else if (r_flush) begin
                    n_state = S_FLUSH;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_LOW: begin
                if (i_status.q_count != 2'd0) begin
                    n_state = S_TAKE;
                end else if (r_flush) begin
                    n_state = S_FLUSH;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (i_status.pend_count != 2'd0) begin
                    n_state = (i_status.pend_count > 2'd1) ? S_TAKE : S_FLUSH;
                end else if (!r_end || i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && w_take_byte) begin
                    o_cmd = CMD_LOAD;
                end
            end
            S_TAKE:  o_cmd = CMD_TAKE;
            S_LOW:   o_cmd = CMD_LOW;
            S_FLUSH: begin
                if (i_status.pend_count != 2'd0) begin
                    o_cmd = CMD_RAW;
                end else if (!r_end) begin
                    o_cmd = CMD_SEP;
                end else if (i_status.out_free) begin
                    o_cmd = CMD_END;
                end
            end
            default: o_cmd = CMD_NONE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_low_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOW) |-> ($past(r_state) == S_TAKE))
        else $error("low surrogate step without a preceding take");

    a_take_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAKE) |-> (i_status.q_count != 2'd0))
        else $error("take step with an empty byte queue");

    a_idle_queue_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (i_status.q_count == 2'd0))
        else $error("bytes left in the queue while idle");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/udh_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module udh_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  udh_pkg::t_cmd                 i_cmd,
    input  logic [7:0]                    i_byte,
    input  logic                          i_cfg_we,
    input  logic [udh_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [udh_pkg::KEY_W-1:0]     i_cfg_data,
    output udh_pkg::t_status              o_status,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [udh_pkg::KEY_W-1:0]     o_key_first,
    output logic [udh_pkg::KEY_W-1:0]     o_key_second
);
    import udh_pkg::*;

    logic [KEY_W-1:0] r_seed1, r_seed2;
    logic [KEY_W-1:0] r_lane1, r_lane2;
    logic [KEY_W-1:0] r_key1, r_key2;
    logic [7:0]       r_pb [3];
    logic [7:0]       r_q  [2];
    logic [1:0]       r_qn;
    logic [1:0]       r_pc, n_pc;
    logic [2:0]       r_sl, n_sl;
    logic [15:0]      r_low;
    logic             r_ovalid;

    logic [7:0]  w_b;
    logic [2:0]  w_len;
    logic [20:0] w_cp;
    logic [20:0] w_v;
    logic [15:0] w_hi, w_lo;
    logic        w_long;
    logic        t_store;
    logic [1:0]  t_idx;
    logic        t_has_unit;
    logic        t_long;
    logic [15:0] t_unit;
    logic        w_upd;
    logic [15:0] w_unit;

    assign w_b   = r_q[0];
    assign w_len = lead_length(w_b);

    // code point of a completed sequence
    always_comb begin
        unique case (r_sl)
            3'd2:    w_cp = {10'd0, r_pb[0][4:0], w_b[5:0]};
            3'd3:    w_cp = {5'd0, r_pb[0][3:0], r_pb[1][5:0], w_b[5:0]};
            default: w_cp = {r_pb[0][2:0], r_pb[1][5:0], r_pb[2][5:0], w_b[5:0]};
        endcase
    end

    assign w_v    = w_cp - 21'h01_0000;
    assign w_hi   = 16'hd800 + {5'd0, w_v[20:10]};
    assign w_lo   = 16'hdc00 + {6'd0, w_v[9:0]};
    assign w_long = |w_cp[20:16];

    // one byte through the decoder
    always_comb begin
        t_store    = 1'b0;
        t_idx      = r_pc;
        t_has_unit = 1'b0;
        t_long     = 1'b0;
        t_unit     = {8'd0, w_b};
        n_pc       = r_pc;
        n_sl       = r_sl;
        if (r_pc == 2'd0) begin
            if (w_len <= 3'd1) begin
                // ascii or a byte that cannot lead goes in raw
                t_has_unit = 1'b1;
            end else begin
                t_store = 1'b1;
                t_idx   = 2'd0;
                n_pc    = 2'd1;
                n_sl    = w_len;
            end
        end else if (({1'b0, r_pc} + 3'd1) >= r_sl) begin
            n_pc       = 2'd0;
            n_sl       = 3'd0;
            t_has_unit = 1'b1;
            t_long     = w_long;
            t_unit     = w_long ? w_hi : w_cp[15:0];
        end else begin
            t_store = 1'b1;
            n_pc    = r_pc + 2'd1;
        end
    end

    // lane update source
    always_comb begin
        w_upd  = 1'b0;
        w_unit = 16'd0;
        unique case (i_cmd)
            CMD_TAKE: begin
                w_upd  = t_has_unit;
                w_unit = t_unit;
            end
            CMD_LOW: begin
                w_upd  = 1'b1;
                w_unit = r_low;
            end
            CMD_RAW: begin
                w_upd  = 1'b1;
                w_unit = {8'd0, r_pb[0]};
            end
            CMD_SEP: begin
                w_upd  = 1'b1;
                w_unit = 16'd0;
            end
            default: begin
                w_upd  = 1'b0;
                w_unit = 16'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed1  <= SEED_FIRST_RST;
            r_seed2  <= SEED_SECOND_RST;
            r_lane1  <= SEED_FIRST_RST;
            r_lane2  <= SEED_SECOND_RST;
            r_qn     <= 2'd0;
            r_pc     <= 2'd0;
            r_sl     <= 3'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SEED_FIRST:  r_seed1 <= i_cfg_data;
                    CFG_SEED_SECOND: r_seed2 <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (w_upd) begin
                r_lane1 <= hash_step(r_lane1, w_unit);
                r_lane2 <= hash_step(r_lane2, w_unit);
            end
            unique case (i_cmd)
                CMD_LOAD: r_qn <= 2'd1;
                CMD_TAKE: begin
                    r_qn <= r_qn - 2'd1;
                    r_pc <= n_pc;
                    r_sl <= n_sl;
                end
                CMD_RAW: begin
                    r_qn <= r_pc - 2'd1;
                    r_pc <= 2'd0;
                    r_sl <= 3'd0;
                end
                CMD_END: begin
                    r_ovalid <= 1'b1;
                    r_lane1  <= r_seed1;
                    r_lane2  <= r_seed2;
                end
                default: ;
            endcase
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            CMD_LOAD: r_q[0] <= i_byte;
            CMD_TAKE: begin
                r_q[0] <= r_q[1];
                r_low  <= w_lo;
                if (t_store) begin
                    r_pb[t_idx] <= w_b;
                end
            end
            CMD_RAW: begin
                // bytes after the raw lead are scanned again
                r_q[0] <= r_pb[1];
                r_q[1] <= r_pb[2];
            end
            CMD_END: begin
                r_key1 <= r_lane1;
                r_key2 <= r_lane2;
            end
            default: ;
        endcase
    end

    assign o_status.q_count    = r_qn;
    assign o_status.pend_count = r_pc;
    assign o_status.take_long  = t_long;
    assign o_status.out_free   = !r_ovalid || i_out_ready;

    assign o_out_valid  = r_ovalid;
    assign o_key_first  = r_key1;
    assign o_key_second = r_key2;

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_utf16_dual_string_hash.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Hashes a key given as a stream of UTF-8 bytes into two 32-bit lanes, each updated
// per UTF-16 code unit as h = h*31 + unit. A text beat (op 0) is accepted and then
// decoded, with an extra step for the low half when it completes a code point above
// 0xFFFF (surrogate pair); zero bytes and op 3 are only accepted. A separator (op 1)
// or end (op 2) beat flushes pending bytes: each cut-off lead byte goes in raw and
// the bytes after it are scanned again; a separator then mixes in a zero unit. The
// input is not ready again until a beat is done. Both lanes share one update source
// (one shift-subtract-add per cycle). The end beat emits both lanes through an output
// register and reloads the seeds; it waits while a previous result has not been taken.
// Seed writes (index 0 first lane, index 1 second lane) apply from the next end beat.
module utf8_utf16_dual_string_hash (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    udh_in_if.sink                        i_in,
    udh_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [udh_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [udh_pkg::KEY_W-1:0]     i_cfg_data
);
    import udh_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    udh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_op     (i_in.op),
        .i_in_byte_nz(i_in.text_byte != 8'd0),
        .o_in_ready  (i_in.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    udh_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_byte      (i_in.text_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_status    (w_status),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_key_first (o_out.key_first),
        .o_key_second(o_out.key_second)
    );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import udh_pkg::*;

    localparam logic [1:0] OP_NOP     = 2'd3;
    localparam int         SETTLE_CYC = 16;
    localparam int         HOLD_CYC   = 300;
    localparam int         PHASE_BEATS = 125;

    typedef enum logic {ROW_BEAT, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [1:0]            op;
        logic [7:0]            val;
        logic [CFG_IDX_W-1:0]  cidx;
        logic [31:0]           cdata;
        logic                  chk;
        logic [31:0]           want1;
        logic [31:0]           want2;
    } t_step_row;

    typedef struct packed {
        logic [31:0] key_first;
        logic [31:0] key_second;
    } t_key_pair;

    localparam int DIR_N = 27;
    localparam t_step_row DIR_ROWS [DIR_N] = '{
        '{ROW_BEAT, OP_END,  8'h00, CFG_SEED_FIRST,  32'h0, 1'b1, SEED_FIRST_RST, SEED_SECOND_RST},
        '{ROW_CFG,  OP_BYTE, 8'h00, CFG_SEED_FIRST,  32'h0, 1'b0, 32'h0, 32'h0},
        '{ROW_CFG,  OP_BYTE, 8'h00, CFG_SEED_SECOND, 32'h0, 1'b0, 32'h0, 32'h0},
        // seed writes only land at the next end beat
        '{ROW_BEAT, OP_END,  8'hff, CFG_SEED_FIRST,  32'h0, 1'b1, SEED_FIRST_RST, SEED_SECOND_RST},
        '{ROW_BEAT, OP_BYTE, 8'h41, CFG_SEED_FIRST,  32'h0, 1'b0, 32'h0, 32'h0},
        '{ROW_BEAT, OP_END,  8'h00, CFG_SEED_FIRST,  32'h0, 1'b1, 32'h41, 32'h41},
        '{ROW_BEAT, OP_BYTE, 8'h00, CFG_SEED_FIRST,  32'h0, 1'b0, 32'h0, 32'h0},
        '{ROW_BEAT, OP_BYTE, 8'hff, CFG_SEED_FIRST,  32'h0, 1'b0, 32'h0, 32'h0},
        '{ROW_BEAT, OP_NOP,  8'ha5, CFG_SEED_FIRST,  32'h0, 1'b0, 32'h0, 32'h0},
        '{ROW_BEAT, OP_SEP,  8'h5a, CFG_SEED_FIRST,  32'h0, 1'b0, 32'h0, 32'h0},
        '{ROW_BEAT, OP_END,  8'h00, CFG_SEED_FIRST,  32'h0, 1'b1, 32'h1ee1, 32'h1ee1},
        '{ROW_BEAT, OP_BYTE, 8'he2, CFG_SEED_FIRST,  32'h0, 1'b0, 32'h0, 32'h0},
        '{ROW_BEAT, OP_BYTE, 8'h82, CFG_SEED_FIRST,  32'h0, 1'b0, 32'h0, 32'h0},
        '{ROW_BEAT, OP_BYTE, 8'hac, CFG_SEED_FIRST,  32'h0, 1'b0, 32'h0, 32'h0},
        '{ROW_BEAT, OP_END,  8'h00, CFG_SEED_FIRST,  32'h0, 1'b1, 32'h20ac, 32'h20ac},
        // code point beyond the unicode range, still split into a surrogate pair
        '{ROW_BEAT, OP_BYTE, 8'hf7, CFG_SEED_FIRST,  32'h0, 1'b0, 32'h0, 32'h0},
        '{ROW_BEAT, OP_BYTE, 8'hbf, CFG_SEED_FIRST,  32'h0, 1'b0, 32'h0, 32'h0},
        '{ROW_BEAT, OP_BYTE, 8'hbf, CFG_SEED_FIRST,  32'h0, 1'b0, 32'h0, 32'h0},
        '{ROW_BEAT, OP_BYTE, 8'hbf, CFG_SEED_FIRST,  32'h0, 1'b0, 32'h0, 32'h0},
        '{ROW_CFG,  OP_BYTE, 8'h00, CFG_SEED_FIRST,  32'hffff_ffff, 1'b0, 32'h0, 32'h0},
        '{ROW_CFG,  OP_BYTE, 8'h00, CFG_SEED_SECOND, 32'hffff_ffff, 1'b0, 32'h0, 32'h0},
        '{ROW_BEAT, OP_END,  8'h00, CFG_SEED_FIRST,  32'h0, 1'b0, 32'h0, 32'h0},
        '{ROW_BEAT, OP_END,  8'h00, CFG_SEED_FIRST,  32'h0, 1'b1, 32'hffff_ffff, 32'hffff_ffff},
        // cut-short lead, the rescan starts a new sequence that completes
        '{ROW_BEAT, OP_BYTE, 8'hf7, CFG_SEED_FIRST,  32'h0, 1'b0, 32'h0, 32'h0},
        '{ROW_BEAT, OP_BYTE, 8'hc3, CFG_SEED_FIRST,  32'h0, 1'b0, 32'h0, 32'h0},
        '{ROW_BEAT, OP_BYTE, 8'h41, CFG_SEED_FIRST,  32'h0, 1'b0, 32'h0, 32'h0},
        '{ROW_BEAT, OP_END,  8'h00, CFG_SEED_FIRST,  32'h0, 1'b0, 32'h0, 32'h0}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [KEY_W-1:0]     cfg_data;

    udh_in_if  in_if ();
    udh_out_if out_if ();

    utf8_utf16_dual_string_hash u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // predictor state
    logic [31:0] pred_seed1, pred_seed2;
    logic [31:0] pred_lane1, pred_lane2;
    logic [7:0]  part_bytes [3];
    int unsigned part_cnt, part_len;

    t_key_pair   keys_due [$];
    t_key_pair   key_got;
    int          mismatches;
    int          beat_cnt, keys_seen, surr_cnt, cut_cnt, seed_writes;
    int          burst_left;
    int          rx_hold_len;
    int          rx_mode, rx_mode_left, rx_tick;

    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #5ms;
        $display("FAIL");
        $finish;
    end

    function automatic void mix_unit(input logic [31:0] u);
        pred_lane1 = pred_lane1 * 32'd31 + u;
        pred_lane2 = pred_lane2 * 32'd31 + u;
    endfunction

    function automatic void mix_code_point(input logic [31:0] cp);
        logic [31:0] v;
        if (cp <= 32'hffff) begin
            mix_unit(cp);
        end else begin
            v = cp - 32'h1_0000;
            mix_unit(32'hd800 + (v >> 10));
            mix_unit(32'hdc00 + (v & 32'h3ff));
            surr_cnt += 2;
        end
    endfunction

    function automatic int unsigned utf8_span(input logic [7:0] b);
        if (b < 8'h80) return 1;
        if (b[7:5] == 3'b110) return 2;
        if (b[7:4] == 4'b1110) return 3;
        if (b[7:3] == 5'b11110) return 4;
        return 0;
    endfunction

    function automatic void feed_utf8_byte(input logic [7:0] b);
        logic [31:0] cp;
        int unsigned span;
        if (part_cnt == 0) begin
            span = utf8_span(b);
            if (span <= 1) begin
                mix_code_point({24'd0, b});
            end else begin
                part_bytes[0] = b;
                part_cnt = 1;
                part_len = span;
            end
        end else if (part_cnt + 1 >= part_len) begin
            // continuation bytes are taken whatever their form
            case (part_len)
                2: cp = {21'd0, part_bytes[0][4:0], b[5:0]};
                3: cp = {16'd0, part_bytes[0][3:0], part_bytes[1][5:0], b[5:0]};
                default: cp = {11'd0, part_bytes[0][2:0], part_bytes[1][5:0],
                               part_bytes[2][5:0], b[5:0]};
            endcase
            part_cnt = 0;
            part_len = 0;
            mix_code_point(cp);
        end else begin
            part_bytes[part_cnt] = b;
            part_cnt++;
        end
    endfunction

    // cut-short lead goes in raw, the bytes after it are scanned again
    function automatic void drain_partial();
        logic [7:0]  snap [3];
        int unsigned n;
        while (part_cnt != 0) begin
            n = part_cnt;
            snap = part_bytes;
            part_cnt = 0;
            part_len = 0;
            cut_cnt++;
            mix_code_point({24'd0, snap[0]});
            for (int unsigned i = 1; i < n; i++) feed_utf8_byte(snap[i]);
        end
    endfunction

    function automatic logic [7:0] lead_for(input int unsigned span);
        case (span)
            2: return 8'hc0 | 8'($urandom_range(0, 31));
            3: return 8'he0 | 8'($urandom_range(0, 15));
            default: return 8'hf0 | 8'($urandom_range(0, 7));
        endcase
    endfunction

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %08h want %08h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic send_item(input logic [1:0] op, input logic [7:0] b,
                             input logic has_want = 1'b0,
                             input logic [31:0] want1 = 32'h0,
                             input logic [31:0] want2 = 32'h0);
        int        gap;
        t_key_pair k;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_if.valid     <= 1'b1;
        in_if.op        <= op;
        in_if.text_byte <= b;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        burst_left--;
        if (!(op == OP_NOP || (op == OP_BYTE && b == 8'h00))) beat_cnt++;
        case (op)
            OP_BYTE: begin
                if (b != 8'h00) feed_utf8_byte(b);
            end
            OP_SEP: begin
                drain_partial();
                pred_lane1 = pred_lane1 * 32'd31;
                pred_lane2 = pred_lane2 * 32'd31;
            end
            OP_END: begin
                drain_partial();
                k.key_first  = has_want ? want1 : pred_lane1;
                k.key_second = has_want ? want2 : pred_lane2;
                keys_due.push_back(k);
                pred_lane1 = pred_seed1;
                pred_lane2 = pred_seed2;
            end
            default: ;
        endcase
    endtask

    // stop offering, wait for every key, then let any trailing flush finish
    task automatic settle_idle();
        in_if.valid <= 1'b0;
        while (keys_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_seed(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SEED_FIRST) pred_seed1 = val;
        else pred_seed2 = val;
        seed_writes++;
        @(posedge clk);
    endtask

    task automatic send_cut_lead();
        int unsigned span;
        span = $urandom_range(2, 4);
        send_item(OP_BYTE, lead_for(span));
        repeat ($urandom_range(0, span - 2)) send_item(OP_BYTE, cont_byte());
    endtask

    task automatic send_random_key();
        int unsigned n_chars, pick, span;
        n_chars = $urandom_range(0, 6);
        repeat (n_chars) begin
            pick = $urandom_range(0, 99);
            if (pick < 28) begin
                send_item(OP_BYTE, 8'($urandom_range(1, 127)));
            end else if (pick < 78) begin
                span = (pick < 48) ? 2 : (pick < 64) ? 3 : 4;
                send_item(OP_BYTE, lead_for(span));
                repeat (span - 1) send_item(OP_BYTE, cont_byte());
            end else if (pick < 84) begin
                send_item(OP_SEP, 8'($urandom));
            end else if (pick < 92) begin
                send_cut_lead();
                if ($urandom_range(0, 1) == 1) send_item(OP_SEP, 8'($urandom));
            end else if (pick < 97) begin
                send_item(OP_BYTE, 8'($urandom));
            end else begin
                send_item(OP_NOP, 8'($urandom));
            end
        end
        if ($urandom_range(0, 4) == 0) send_cut_lead();
        send_item(OP_END, 8'($urandom));
    endtask

    // receiver: runs of always-ready, random stalls and a fixed duty pattern
    initial begin
        out_if.ready <= 1'b0;
        rx_hold_len  = 0;
        rx_mode      = 0;
        rx_mode_left = 0;
        rx_tick      = 0;
        forever begin
            @(posedge clk);
            rx_tick++;
            if (rx_hold_len > 0) begin
                out_if.ready <= 1'b0;
                rx_hold_len--;
            end else begin
                if (rx_mode_left <= 0) begin
                    rx_mode      = $urandom_range(0, 2);
                    rx_mode_left = $urandom_range(8, 60);
                end
                rx_mode_left--;
                case (rx_mode)
                    0: out_if.ready <= 1'b1;
                    1: out_if.ready <= ($urandom_range(0, 3) != 0);
                    default: out_if.ready <= ((rx_tick % 7) >= 2);
                endcase
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_if.valid && out_if.ready) begin
            keys_seen++;
            if (keys_due.size() == 0) begin
                report_mismatch("key with none outstanding", out_if.key_first, 32'h0);
            end else begin
                key_got = keys_due.pop_front();
                if (out_if.key_first !== key_got.key_first)
                    report_mismatch("key_first", out_if.key_first, key_got.key_first);
                if (out_if.key_second !== key_got.key_second)
                    report_mismatch("key_second", out_if.key_second, key_got.key_second);
            end
        end
    end

    initial begin
        int phase_goal;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_idx         <= CFG_SEED_FIRST;
        cfg_data        <= '0;
        in_if.valid     <= 1'b0;
        in_if.op        <= OP_BYTE;
        in_if.text_byte <= 8'h00;
        mismatches  = 0;
        beat_cnt    = 0;
        keys_seen   = 0;
        surr_cnt    = 0;
        cut_cnt     = 0;
        seed_writes = 0;
        burst_left  = 0;
        pred_seed1  = SEED_FIRST_RST;
        pred_seed2  = SEED_SECOND_RST;
        pred_lane1  = SEED_FIRST_RST;
        pred_lane2  = SEED_SECOND_RST;
        part_bytes  = '{8'h00, 8'h00, 8'h00};
        part_cnt    = 0;
        part_len    = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_N; r++) begin
            if (DIR_ROWS[r].kind == ROW_CFG) begin
                settle_idle();
                write_seed(DIR_ROWS[r].cidx, DIR_ROWS[r].cdata);
            end else begin
                send_item(DIR_ROWS[r].op, DIR_ROWS[r].val, DIR_ROWS[r].chk,
                          DIR_ROWS[r].want1, DIR_ROWS[r].want2);
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            settle_idle();
            case (ph)
                0: begin
                    write_seed(CFG_SEED_FIRST, SEED_FIRST_RST);
                    write_seed(CFG_SEED_SECOND, SEED_SECOND_RST);
                end
                2: begin
                    write_seed(CFG_SEED_FIRST, 32'h0);
                    write_seed(CFG_SEED_SECOND, 32'hffff_ffff);
                end
                default: begin
                    write_seed(CFG_SEED_FIRST, $urandom);
                    write_seed(CFG_SEED_SECOND, $urandom);
                end
            endcase
            // long receiver stall while text keeps coming, so the input backs up
            if (ph == 1) rx_hold_len = HOLD_CYC;
            phase_goal = beat_cnt + PHASE_BEATS;
            while (beat_cnt < phase_goal) send_random_key();
        end

        settle_idle();
        $display("covered %0d hashed beats across %0d seed writes, %0d keys compared",
                 beat_cnt, seed_writes, keys_seen);
        $display("predicted %0d surrogate units and %0d cut-short lead bytes",
                 surr_cnt, cut_cnt);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/udh_pkg.sv
hw/rtl/udh_in_if.sv
hw/rtl/udh_out_if.sv
hw/rtl/udh_ctrl.sv
hw/rtl/udh_datapath.sv
hw/rtl/utf8_utf16_dual_string_hash.sv
sim/tb_top.sv
